FILE: design/rmq_pkg.sv
// Package for the rotation matrix to quaternion converter.
// Holds the port word types, datapath widths and a small helper.
// No dependencies; every other design file imports it.
`default_nettype none

package rmq_pkg;

  // One matrix word on the input channel, signed Q2.14 entries
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_word_t;

  // One quaternion word on the output channel, signed Q2.14 components
  typedef struct packed {
    logic signed [15:0] q_scalar;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic               degenerate;
  } quat_word_t;

  localparam int VW    = 18;  // branch vector element, signed
  localparam int MW    = 17;  // magnitude of a vector element
  localparam int SQW   = 34;  // square of a magnitude
  localparam int SW    = 36;  // sum of four squares
  localparam int QW    = 54;  // running product u * s, signed
  localparam int PW    = 72;  // running product u * u * s, signed
  localparam int RW    = 15;  // rounded result before clamp
  localparam int NSTEP = 15;  // one result bit per step
  localparam int MSH   = 30;  // scale of the squared magnitude bound

  localparam logic signed [VW-1:0] ONE_V  = 18'sd16384;
  localparam logic [RW-1:0]        ONE_R  = 15'd16384;

  // Sign extend a matrix entry to vector width
  function automatic logic signed [VW-1:0] ext16(logic signed [15:0] x);
    return {{(VW-16){x[15]}}, x};
  endfunction

endpackage

`default_nettype wire

FILE: design/rmq_front.sv
// Front end of the converter: branch choice, squares and sum of squares.
// Three register stages, each advanced by its own enable. Uses rmq_pkg.
`default_nettype none

module rmq_front
  import rmq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic [2:0]               en,
  input  wire mat_word_t                mat,
  output logic      [SW-1:0]            s,
  output logic      [3:0][SQW-1:0]      sq,
  output logic      [3:0]               neg
);

  logic signed [VW-1:0] a, b, c, e, f, g, i, j, k, t;
  logic signed [VW-1:0] v_next [4];
  logic        [3:0][VW-1:0]  v;
  logic        [3:0][SQW-1:0] sq1;
  logic        [3:0]          neg1;

  // Pick the branch and build the unnormalized vector
  always_comb begin
    a = ext16(mat.m00); b = ext16(mat.m01); c = ext16(mat.m02);
    e = ext16(mat.m10); f = ext16(mat.m11); g = ext16(mat.m12);
    i = ext16(mat.m20); j = ext16(mat.m21); k = ext16(mat.m22);
    t = a + f + k;
    if (t > 0) begin
      v_next[0] = ONE_V + t;
      v_next[1] = j - g; v_next[2] = c - i; v_next[3] = e - b;
    end else if (a > f && a > k) begin
      v_next[1] = ONE_V + a - f - k;
      v_next[0] = j - g; v_next[2] = b + e; v_next[3] = c + i;
    end else if (f > k) begin
      v_next[2] = ONE_V + f - a - k;
      v_next[0] = c - i; v_next[1] = b + e; v_next[3] = g + j;
    end else begin
      v_next[3] = ONE_V + k - a - f;
      v_next[0] = e - b; v_next[1] = c + i; v_next[2] = g + j;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int n = 0; n < 4; n++) v[n] <= v_next[n];
    end
  end

  // Square each magnitude, keep the sign
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int n = 0; n < 4; n++) begin
        logic [VW-1:0] mag;
        mag = v[n][VW-1] ? (~v[n] + VW'(1)) : v[n];
        sq1[n]  <= SQW'(mag[MW-1:0]) * SQW'(mag[MW-1:0]);
        neg1[n] <= v[n][VW-1];
      end
    end
  end

  // Sum the squares
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s   <= SW'(sq1[0]) + SW'(sq1[1]) + SW'(sq1[2]) + SW'(sq1[3]);
      sq  <= sq1;
      neg <= neg1;
    end
  end

endmodule

`default_nettype wire

FILE: design/rmq_norm.sv
// Normalizer: per component, a bit-at-a-time search for the rounded value
// of 16384 * |v| / sqrt(s), one bit per register stage. Uses rmq_pkg.
`default_nettype none

module rmq_norm
  import rmq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [NSTEP-1:0]     en,
  input  wire logic [SW-1:0]        s,
  input  wire logic [3:0][SQW-1:0]  sq,
  input  wire logic [3:0]           neg,
  output logic      [3:0][RW-1:0]   r,
  output logic      [3:0]           neg_out,
  output logic                      zero
);

  // Per stage state; the last stage keeps only the result, sign and zero bits
  logic [NSTEP-1:0][3:0][RW-1:0]  r_st;
  logic [NSTEP-2:0][3:0][PW-1:0]  p_st;
  logic [NSTEP-2:0][3:0][QW-1:0]  q_st;
  logic [NSTEP-2:0][SW-1:0]       s_st;
  logic [NSTEP-2:0][3:0][SQW-1:0] sq_st;
  logic [NSTEP-1:0][3:0]          neg_st;
  logic [NSTEP-1:0]               zero_st;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam int SH = NSTEP - 1 - k;
    localparam logic [RW-1:0] BIT = RW'(1) << SH;
    logic [SW-1:0]  s_in;
    logic [3:0]     neg_in;
    logic           zero_in;

    if (k == 0) begin : g_first
      assign s_in    = s;
      assign neg_in  = neg;
      assign zero_in = (s == '0);
    end else begin : g_next
      assign s_in    = s_st[k-1];
      assign neg_in  = neg_st[k-1];
      assign zero_in = zero_st[k-1];
    end

    // Carry the side bits
    always_ff @(posedge clk) begin
      if (en[k]) begin
        neg_st[k]  <= neg_in;
        zero_st[k] <= zero_in;
      end
    end

    if (k < NSTEP - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) s_st[k] <= s_in;
      end
    end

    for (genvar n = 0; n < 4; n++) begin : g_lane
      logic [RW-1:0]        r_in;
      logic signed [PW-1:0] p_in, p_cand, m_lim, q_ext, s_ext;
      logic signed [QW-1:0] q_in;
      logic [SQW-1:0]       sq_in;
      logic                 take;

      // Start with r = 0: u = -1, so u*u*s = s and u*s = -s
      if (k == 0) begin : g_init
        assign r_in  = '0;
        assign p_in  = $signed({{(PW-SW){1'b0}}, s});
        assign q_in  = -$signed({{(QW-SW){1'b0}}, s});
        assign sq_in = sq[n];
      end else begin : g_prev
        assign r_in  = r_st[k-1][n];
        assign p_in  = $signed(p_st[k-1][n]);
        assign q_in  = $signed(q_st[k-1][n]);
        assign sq_in = sq_st[k-1][n];
      end

      // Try the bit: (u + 2b)^2 s = u^2 s + 4b u s + 4b^2 s, against |v|^2 2^30
      always_comb begin
        q_ext  = {{(PW-QW){q_in[QW-1]}}, q_in};
        s_ext  = $signed({{(PW-SW){1'b0}}, s_in});
        p_cand = p_in + (q_ext <<< (SH + 2)) + (s_ext <<< (2 * SH + 2));
        m_lim  = $signed({{(PW-SQW-MSH){1'b0}}, sq_in, {MSH{1'b0}}});
        take   = (p_cand <= m_lim);
      end

      always_ff @(posedge clk) begin
        if (en[k]) r_st[k][n] <= take ? (r_in | BIT) : r_in;
      end

      if (k < NSTEP - 1) begin : g_keep
        always_ff @(posedge clk) begin
          if (en[k]) begin
            p_st[k][n]  <= take ? p_cand : p_in;
            q_st[k][n]  <= take ? (q_in + QW'(s_ext <<< (SH + 1))) : q_in;
            sq_st[k][n] <= sq_in;
          end
        end
      end
    end
  end

  assign r       = r_st[NSTEP-1];
  assign neg_out = neg_st[NSTEP-1];
  assign zero    = zero_st[NSTEP-1];

endmodule

`default_nettype wire

FILE: design/rotation_matrix_to_quat.sv
// Top level of the rotation matrix to unit quaternion converter.
// Instantiates rmq_front and rmq_norm, holds the valid chain and output word.
//
//   channel | word        | handshake           | direction
//   --------+-------------+---------------------+----------
//   mat     | mat_word_t  | mat_valid/mat_stall | in
//   quat    | quat_word_t | quat_valid/quat_stall | out
//
// One matrix is taken per cycle while mat_stall is low. There are 3 front-end stages,
// 15 stages of the bit-serial normalizer (one result bit each) and 1 output stage.
// Reset clears the valid bits only; the datapath is not reset.
// A stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stall and mat_stall rises only when every stage
// holds a word and quat_stall is high.
`default_nettype none

module rotation_matrix_to_quat
  import rmq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       mat_valid,
  output logic            mat_stall,
  input  wire mat_word_t  mat,
  output logic            quat_valid,
  input  wire logic       quat_stall,
  output quat_word_t      quat
);

  localparam int NST = NSTEP + 4;

  logic [NST-1:0]      en, vld;
  logic [SW-1:0]       s;
  logic [3:0][SQW-1:0] sq;
  logic [3:0]          neg, neg_o;
  logic [3:0][RW-1:0]  r;
  logic                zero;
  logic [3:0][15:0]    comp;
  quat_word_t          quat_next;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NST-1] = !vld[NST-1] || !quat_stall;
    for (int n = NST - 2; n >= 0; n--) en[n] = !vld[n] || en[n+1];
  end

  assign mat_stall  = !en[0];
  assign quat_valid = vld[NST-1];

  // Move the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= mat_valid;
      for (int n = 1; n < NST; n++) begin
        if (en[n]) vld[n] <= vld[n-1];
      end
    end
  end

  rmq_front u_front (
    .clk (clk),
    .en  (en[2:0]),
    .mat (mat),
    .s   (s),
    .sq  (sq),
    .neg (neg)
  );

  rmq_norm u_norm (
    .clk     (clk),
    .en      (en[NSTEP+2:3]),
    .s       (s),
    .sq      (sq),
    .neg     (neg),
    .r       (r),
    .neg_out (neg_o),
    .zero    (zero)
  );

  // Clamp, apply sign, zero out a degenerate word
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      logic [15:0] mag;
      mag = (r[n] > ONE_R) ? {1'b0, ONE_R} : {1'b0, r[n]};
      comp[n] = zero ? 16'd0 : (neg_o[n] ? (~mag + 16'd1) : mag);
    end
    quat_next.q_scalar   = $signed(comp[0]);
    quat_next.q_x        = $signed(comp[1]);
    quat_next.q_y        = $signed(comp[2]);
    quat_next.q_z        = $signed(comp[3]);
    quat_next.degenerate = zero;
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) quat <= quat_next;
  end

  // Input stalls only when the whole pipeline is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    mat_stall |-> (quat_valid && quat_stall && (&vld)))
    else $error("input stalled with room in the pipeline");

  // A degenerate word carries all-zero components
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (quat_valid && quat.degenerate) |->
      (quat.q_scalar == 16'sd0 && quat.q_x == 16'sd0 &&
       quat.q_y == 16'sd0 && quat.q_z == 16'sd0))
    else $error("degenerate word with nonzero component");

  // Unit components never exceed one in magnitude
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    quat_valid |->
      (quat.q_scalar <= 16'sd16384 && quat.q_scalar >= -16'sd16384 &&
       quat.q_x <= 16'sd16384 && quat.q_x >= -16'sd16384 &&
       quat.q_y <= 16'sd16384 && quat.q_y >= -16'sd16384 &&
       quat.q_z <= 16'sd16384 && quat.q_z >= -16'sd16384))
    else $error("quaternion component out of unit range");

  // A unit quaternion has at least one nonzero component
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (quat_valid && !quat.degenerate) |->
      (quat.q_scalar != 16'sd0 || quat.q_x != 16'sd0 ||
       quat.q_y != 16'sd0 || quat.q_z != 16'sd0))
    else $error("normalized quaternion is all zero");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for rotation_matrix_to_quat: drives matrix words, predicts each
// quaternion word with a local bit-exact model, and compares in order.
// Depends on rmq_pkg and the rotation_matrix_to_quat RTL.
`timescale 1ns / 1ps

module testbench
  import rmq_pkg::*;
;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       mat_valid = 1'b0;
  logic       mat_stall;
  mat_word_t  mat = '0;
  logic       quat_valid;
  logic       quat_stall = 1'b0;
  quat_word_t quat;

  quat_word_t expected_quats[$];
  int         error_count = 0;
  int         quats_seen = 0;
  int         mats_sent = 0;
  int         degenerate_seen = 0;
  int         branch_hits[4] = '{0, 0, 0, 0};

  rotation_matrix_to_quat u_dut (
    .clk(clk), .rst(rst),
    .mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
    .quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Round 16384 * v / sqrt(s), ties away from zero, by bitwise search
  function automatic logic [15:0] unit_component(longint v, longint unsigned s);
    longint unsigned mag;
    logic [127:0] lhs;
    logic [127:0] rhs;
    longint unsigned r;
    longint unsigned c;
    longint unsigned odd;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    rhs = 128'(mag * mag) << 30;
    r = 0;
    for (int b = 14; b >= 0; b--) begin
      c = r | (64'd1 << b);
      odd = 2 * c - 1;
      lhs = 128'(odd * odd) * 128'(s);
      if (lhs <= rhs) r = c;
    end
    if (r > 16384) r = 16384;
    if (v < 0) r = -r;
    return r[15:0];
  endfunction

  // Pick the branch, form the vector, normalize it
  function automatic quat_word_t matrix_to_quat(mat_word_t w);
    longint a, b, c, e, f, g, i, j, k;
    longint v[4];
    longint unsigned s;
    quat_word_t q;
    a = w.m00; b = w.m01; c = w.m02;
    e = w.m10; f = w.m11; g = w.m12;
    i = w.m20; j = w.m21; k = w.m22;
    if (a + f + k > 0) begin
      v[0] = 16384 + a + f + k; v[1] = j - g; v[2] = c - i; v[3] = e - b;
      branch_hits[0]++;
    end else if (a > f && a > k) begin
      v[1] = 16384 + a - f - k; v[0] = j - g; v[2] = b + e; v[3] = c + i;
      branch_hits[1]++;
    end else if (f > k) begin
      v[2] = 16384 + f - a - k; v[0] = c - i; v[1] = b + e; v[3] = g + j;
      branch_hits[2]++;
    end else begin
      v[3] = 16384 + k - a - f; v[0] = e - b; v[1] = c + i; v[2] = g + j;
      branch_hits[3]++;
    end
    s = 0;
    for (int n = 0; n < 4; n++) s += longint'(v[n] * v[n]);
    q = '0;
    if (s == 0) begin
      q.degenerate = 1'b1;
      return q;
    end
    q.q_scalar = unit_component(v[0], s);
    q.q_x      = unit_component(v[1], s);
    q.q_y      = unit_component(v[2], s);
    q.q_z      = unit_component(v[3], s);
    return q;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("mismatch on quat %0d: %s got %0d want %0d", quats_seen, what, got, want);
  endtask

  // Send one matrix word, record its prediction at acceptance; drop valid
  // only across a gap so that back-to-back words keep it high
  task automatic send_matrix(mat_word_t w);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      mat_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mat <= w;
    mat_valid <= 1'b1;
    do @(posedge clk); while (mat_stall);
    expected_quats.push_back(matrix_to_quat(w));
    mats_sent++;
  endtask

  // Random stall on the quat side
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) begin
        quat_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        quat_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        quat_stall <= 1'b1;
      end else begin
        quat_stall <= ($urandom_range(0, 99) < 3);
      end
    end
  end

  // Check each accepted quat word against the oldest prediction
  always @(posedge clk) begin
    quat_word_t want;
    if (!rst && quat_valid && !quat_stall) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_quats.pop_front();
        if (quat.q_scalar !== want.q_scalar)
          report_mismatch("q_scalar", quat.q_scalar, want.q_scalar);
        if (quat.q_x !== want.q_x) report_mismatch("q_x", quat.q_x, want.q_x);
        if (quat.q_y !== want.q_y) report_mismatch("q_y", quat.q_y, want.q_y);
        if (quat.q_z !== want.q_z) report_mismatch("q_z", quat.q_z, want.q_z);
        if (quat.degenerate !== want.degenerate)
          report_mismatch("degenerate", quat.degenerate, want.degenerate);
        if (quat.degenerate === 1'b1) degenerate_seen++;
      end
      quats_seen++;
    end
  end

  function automatic mat_word_t rotation_like(int dom);
    mat_word_t w;
    logic signed [15:0] d[3];
    for (int n = 0; n < 3; n++) d[n] = 16'($signed($urandom_range(0, 32767)) - 16384);
    d[dom] = 16'($urandom_range(0, 16384));
    w.m00 = d[0]; w.m11 = d[1]; w.m22 = d[2];
    w.m01 = 16'($urandom); w.m02 = 16'($urandom); w.m10 = 16'($urandom);
    w.m12 = 16'($urandom); w.m20 = 16'($urandom); w.m21 = 16'($urandom);
    return w;
  endfunction

  // Identity, extremes and all four branches
  task automatic test_directed();
    mat_word_t w;
    w = '0; w.m00 = 16'sd16384; w.m11 = 16'sd16384; w.m22 = 16'sd16384;
    send_matrix(w);
    w = '0;
    send_matrix(w);
    w = '{default: 16'sh7fff};
    send_matrix(w);
    w = '{default: 16'sh8000};
    send_matrix(w);
    w = '0; w.m00 = 16'sd16384; w.m11 = -16'sd16384; w.m22 = -16'sd16384;
    send_matrix(w);
    w = '0; w.m00 = -16'sd16384; w.m11 = 16'sd16384; w.m22 = -16'sd16384;
    send_matrix(w);
    w = '0; w.m00 = -16'sd16384; w.m11 = -16'sd16384; w.m22 = 16'sd16384;
    send_matrix(w);
    w = '0; w.m00 = -16'sd16384; w.m11 = -16'sd16384; w.m22 = -16'sd16384;
    send_matrix(w);
    w = '0; w.m01 = 16'sh7fff; w.m10 = 16'sh8000; w.m02 = 16'sh8000; w.m20 = 16'sh7fff;
    w.m12 = 16'sh7fff; w.m21 = 16'sh8000;
    send_matrix(w);
    w = '0; w.m00 = 16'sh8000; w.m11 = 16'sh8000; w.m22 = 16'sh8000;
    w.m01 = 16'sh7fff; w.m10 = 16'sh7fff;
    send_matrix(w);
    w = '0; w.m00 = 16'sh7fff; w.m11 = 16'sh8000; w.m22 = 16'sh8000;
    send_matrix(w);
    // ties between diagonal entries with negative trace
    w = '0; w.m00 = -16'sd8000; w.m11 = -16'sd8000; w.m22 = -16'sd8000;
    send_matrix(w);
    w = '0; w.m00 = -16'sd100; w.m11 = -16'sd100; w.m22 = -16'sd9000;
    send_matrix(w);
  endtask

  // Mostly rotation-scale matrices across branches, some raw noise
  task automatic test_random();
    for (int n = 0; n < 940; n++) begin
      if ($urandom_range(0, 3) == 0) send_matrix(mat_word_t'(144'({$urandom, $urandom,
        $urandom, $urandom, $urandom})));
      else send_matrix(rotation_like($urandom_range(0, 2)));
    end
  endtask

  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    mat_valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d matrices, checked %0d quats, %0d degenerate", mats_sent,
             quats_seen, degenerate_seen);
    $display("branch use: trace %0d, m00 %0d, m11 %0d, m22 %0d", branch_hits[0],
             branch_hits[1], branch_hits[2], branch_hits[3]);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: rotation_matrix_to_quat.f
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_norm.sv
design/rotation_matrix_to_quat.sv
tb/testbench.sv
